[design/ihex_pkg.sv]
// Shared types, character codes and digit decode for the hex record parser.
// Used by ihex_core and intel_hex_record_parser_top; depends on nothing.
`timescale 1ns / 1ps

package ihex_pkg;

    localparam int POS_W = 10;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [POS_W-1:0] POS_MAX        = 10'd1023;
    localparam logic [POS_W-1:0] POS_LENGTH     = 10'd1;
    localparam logic [POS_W-1:0] POS_ADDR_HIGH  = 10'd3;
    localparam logic [POS_W-1:0] POS_ADDR_LOW   = 10'd5;
    localparam logic [POS_W-1:0] POS_FIRST_DATA = 10'd9;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_END   = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic         emit;
        result_kind_t kind;
        logic         out_of_range;
        logic         bad_digit;
    } res_ctrl_t;

    // Returns {valid, nibble}.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

[design/ihex_core.sv]
// Record state and per-character decode for the hex record parser.
// Depends on ihex_pkg; instantiated by intel_hex_record_parser_top.
`timescale 1ns / 1ps

module ihex_core
    import ihex_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            text_char,
    input  logic [ADDR_WIDTH:0]   image_size,
    output res_ctrl_t             res_ctrl,
    output logic [ADDR_WIDTH:0]   res_address,
    output logic [7:0]            res_data,
    output logic [ADDR_WIDTH:0]   res_end_address
);

    localparam int AWP = ADDR_WIDTH + 1;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [15:0]      addr_reg, addr_next;
    logic [3:0]       high_reg, high_next;
    logic [AWP-1:0]   end_reg, end_next;
    logic             bad_reg, bad_next;

    logic [4:0]       dec;
    logic             bad_now;
    logic [7:0]       byte_val;
    logic [POS_W-1:0] pos_off;
    logic [8:0]       data_idx;
    logic [AWP-1:0]   sum;
    logic [AWP-1:0]   wr_addr;

    always_comb
    begin
        dec      = hex_nibble(text_char);
        bad_now  = bad_reg | ~dec[4];
        byte_val = {high_reg, dec[3:0]};
        pos_off  = pos_reg - POS_FIRST_DATA;
        data_idx = pos_off[POS_W-1:1];
        sum      = AWP'(addr_reg) + AWP'(len_reg);
        wr_addr  = AWP'(addr_reg) + AWP'(data_idx);

        pos_next  = pos_reg;
        len_next  = len_reg;
        addr_next = addr_reg;
        high_next = high_reg;
        end_next  = end_reg;
        bad_next  = bad_reg;

        res_ctrl        = '0;
        res_address     = '0;
        res_data        = '0;
        res_end_address = end_reg;

        if (text_char == CH_COLON || text_char == CH_CR)
        begin
            res_ctrl.emit = 1'b0;
        end
        else if (text_char == CH_LF)
        begin
            if (sum != '0)
            begin
                end_next = sum;
            end
            res_ctrl.emit      = 1'b1;
            res_ctrl.kind      = KIND_END;
            res_ctrl.bad_digit = bad_reg;
            res_end_address    = end_next;
            pos_next  = '0;
            len_next  = '0;
            addr_next = '0;
            high_next = '0;
            bad_next  = 1'b0;
        end
        else
        begin
            bad_next = bad_now;
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (!pos_reg[0])
            begin
                high_next = dec[3:0];
            end
            else if (pos_reg == POS_LENGTH)
            begin
                len_next = byte_val;
            end
            else if (pos_reg == POS_ADDR_HIGH)
            begin
                addr_next = {byte_val, addr_reg[7:0]};
            end
            else if (pos_reg == POS_ADDR_LOW)
            begin
                addr_next = {addr_reg[15:8], byte_val};
            end
            else if (pos_reg >= POS_FIRST_DATA && data_idx < {1'b0, len_reg})
            begin
                res_ctrl.emit         = 1'b1;
                res_ctrl.kind         = KIND_WRITE;
                res_ctrl.out_of_range = (wr_addr >= image_size);
                res_ctrl.bad_digit    = bad_now;
                res_address           = wr_addr;
                res_data              = byte_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            addr_reg <= '0;
            high_reg <= '0;
            end_reg  <= '0;
            bad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            addr_reg <= addr_next;
            high_reg <= high_next;
            end_reg  <= end_next;
            bad_reg  <= bad_next;
        end
    end

`ifndef SYNTHESIS
    a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text_char == CH_LF |=> pos_reg == '0 && len_reg == '0 && !bad_reg)
        else $error("Record state not cleared after newline.");

    a_framing_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (text_char == CH_COLON || text_char == CH_CR)
        |=> $stable(pos_reg) && $stable(addr_reg) && $stable(end_reg))
        else $error("Colon or carriage return changed record state.");

    a_write_on_odd_data_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_ctrl.emit && res_ctrl.kind == KIND_WRITE |-> pos_reg[0] && pos_reg >= POS_FIRST_DATA)
        else $error("Data write issued outside the data field.");
`endif

endmodule

[design/intel_hex_record_parser_top.sv]
// Intel HEX record parser, top level: configuration, input/output handshake
// and result register. Depends on ihex_pkg and ihex_core.
`timescale 1ns / 1ps

// The block takes one text character per word on the input channel
// (text_char with in_valid/in_ready) and produces zero or one result word on
// the output channel (out_valid/out_ready): either a data byte write with its
// image address or an end-of-record marker carrying the running end address.
// Colons and carriage returns give no result; neither do header digits.
// Each character is decoded in the cycle it is accepted and its result is
// held in the output register from the next cycle, and a new character can
// be taken every cycle unless the receiver stalls. While a result waits in the
// output register, in_ready stays high as long as out_ready is high in the
// same cycle; when the receiver stalls, input stalls with it and nothing is
// lost. The user must write image_size through cfg_we/cfg_wdata only while
// the block is idle; the block does not enforce this. Writes at or past it
// are flagged out_of_range. Reset clears all record state and the end address,
// sets image_size to the full address space and empties the output register.

module intel_hex_record_parser_top
    import ihex_pkg::*;
#(
    parameter int ADDR_WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [ADDR_WIDTH:0] cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          text_char,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                result_kind,
    output logic [ADDR_WIDTH:0] write_address,
    output logic [7:0]          write_data,
    output logic [ADDR_WIDTH:0] end_address,
    output logic                out_of_range,
    output logic                bad_digit
);

    localparam int AWP = ADDR_WIDTH + 1;
    localparam logic [AWP-1:0] IMAGE_SIZE_RST = {1'b1, {ADDR_WIDTH{1'b0}}};

    logic [AWP-1:0] image_size_reg;
    logic           accept;
    res_ctrl_t      res_ctrl;
    logic [AWP-1:0] res_address;
    logic [7:0]     res_data;
    logic [AWP-1:0] res_end_address;

    logic           valid_reg, valid_next;
    result_kind_t   kind_reg;
    logic [AWP-1:0] addr_reg;
    logic [7:0]     data_reg;
    logic [AWP-1:0] end_reg;
    logic           oor_reg;
    logic           bad_reg;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    ihex_core #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .text_char       (text_char),
        .image_size      (image_size_reg),
        .res_ctrl        (res_ctrl),
        .res_address     (res_address),
        .res_data        (res_data),
        .res_end_address (res_end_address)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= IMAGE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            image_size_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = res_ctrl.emit;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_ctrl.emit)
        begin
            kind_reg <= res_ctrl.kind;
            addr_reg <= res_address;
            data_reg <= res_data;
            end_reg  <= res_end_address;
            oor_reg  <= res_ctrl.out_of_range;
            bad_reg  <= res_ctrl.bad_digit;
        end
    end

    assign out_valid     = valid_reg;
    assign result_kind   = kind_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign end_address   = end_reg;
    assign out_of_range  = oor_reg;
    assign bad_digit     = bad_reg;

`ifndef SYNTHESIS
    a_end_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_END
        |-> write_address == '0 && write_data == '0 && !out_of_range)
        else $error("End-of-record word carries write fields.");

    a_no_emit_drops: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !res_ctrl.emit |=> !out_valid)
        else $error("Output valid after a character that gives no result.");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_ctrl.emit |=> out_valid)
        else $error("Result of an accepted character was lost.");
`endif

endmodule
